### sv/assert_macros.svh
// assertion macro used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### sv/vpd_pkg.sv
// shared types, register indexes and component type codes
// no dependencies
package vpd_pkg;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENDIAN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THREE = 2'd3;
    localparam logic [2:0] CT_U8 = 3'd0;
    localparam logic [2:0] CT_S8 = 3'd1;
    localparam logic [2:0] CT_U16 = 3'd2;
    localparam logic [2:0] CT_S16 = 3'd3;
    localparam logic [2:0] CT_F32 = 3'd4;
    typedef struct packed {
        logic [2:0] comp_type;
        logic [4:0] frac;
        logic       little;
        logic       three;
    } t_cfg;
endpackage

### sv/vpd_lane.sv
// one component converter: raw 4-byte window to single-precision bits
// depends on vpd_pkg
module vpd_lane (
    input  vpd_pkg::t_cfg i_cfg,
    input  logic [31:0]   i_win,   // window bytes, first record byte in 31:24
    output logic [31:0]   o_bits
);
    import vpd_pkg::*;
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] h;
    logic        neg;
    logic [15:0] mag;
    logic [3:0]  lz;
    logic [15:0] norm;
    logic [7:0]  expo;
    logic        is_int;
    always_comb begin
        b0 = i_win[31:24]; b1 = i_win[23:16]; b2 = i_win[15:8]; b3 = i_win[7:0];
        h = i_cfg.little ? {b1, b0} : {b0, b1};
        neg = 1'b0;
        mag = 16'd0;
        is_int = 1'b1;
        unique case (i_cfg.comp_type)
            CT_U8:  mag = {8'd0, b0};
            CT_S8:  begin neg = b0[7]; mag = {8'd0, b0[7] ? 8'(-b0) : b0}; end
            CT_U16: mag = h;
            CT_S16: begin neg = h[15]; mag = h[15] ? 16'(-h) : h; end
            default: is_int = 1'b0;
        endcase
        lz = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (mag[k]) lz = 4'(15 - k);
        end
        norm = mag << lz;
        // exponent 127 + (15 - lz) - frac, never below 96
        expo = 8'(8'd142 - {4'd0, lz} - {3'd0, i_cfg.frac});
        o_bits = 32'd0;
        if (is_int) begin
            if (mag != 16'd0) o_bits = {neg, expo, norm[14:0], 8'd0};
        end else if (i_cfg.comp_type == CT_F32) begin
            o_bits = i_cfg.little ? {b3, b2, b1, b0} : i_win;
        end
    end
endmodule

### sv/vertex_position_dequantize.sv
// top level: config registers, three conversion lanes, output register
// depends on vpd_pkg and vpd_lane
//
// channel   dir  beat contents
// s_axis    in   tdata = raw_front[63:0], raw_back[95:64]
// m_axis    out  tdata = x_bits[31:0], y_bits[63:32], z_bits[95:64]
// cfg       in   index 0 type, 1 fraction bits, 2 little endian, 3 three comps
//
// one beat per cycle unless m_axis stalls; results leave through the output register
// the input is taken whenever the output register is empty or drained
// reset clears the output valid and loads register defaults
module vertex_position_dequantize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // raw_front, raw_back
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_bits, y_bits, z_bits
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [vpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import vpd_pkg::*;
    t_cfg r_cfg;
    logic r_valid;
    logic [95:0] r_data;
    logic [95:0] rec;
    logic [1:0]  stride_sel; // 0 stride 1, 1 stride 2, 2 stride 4
    logic [31:0] win_x, win_y, win_z;
    logic [31:0] x_b, y_b, z_b;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = r_data;

    // record bytes 0..11 with byte 0 at the top, padded in ext for window reads
    assign rec = {s_axis_tdata[63:0], s_axis_tdata[95:64]};

    always_comb begin
        logic [127:0] ext;
        ext = {rec, 32'd0};
        stride_sel = (r_cfg.comp_type == CT_F32) ? 2'd2 :
            ((r_cfg.comp_type == CT_U16 || r_cfg.comp_type == CT_S16) ? 2'd1 : 2'd0);
        win_x = ext[127:96];
        unique case (stride_sel)
            2'd1:    begin win_y = ext[111:80]; win_z = ext[95:64]; end
            2'd2:    begin win_y = ext[95:64];  win_z = ext[63:32]; end
            default: begin win_y = ext[119:88]; win_z = ext[111:80]; end
        endcase
    end

    vpd_lane u_lane_x (.i_cfg(r_cfg), .i_win(win_x), .o_bits(x_b));
    vpd_lane u_lane_y (.i_cfg(r_cfg), .i_win(win_y), .o_bits(y_b));
    vpd_lane u_lane_z (.i_cfg(r_cfg), .i_win(win_z), .o_bits(z_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cfg <= '{comp_type: CT_U8, frac: 5'd0, little: 1'b0, three: 1'b1};
        end else begin
            if (s_axis_tready) r_valid <= s_axis_tvalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TYPE:   r_cfg.comp_type <= i_cfg_data[2:0];
                    REG_FRAC:   r_cfg.frac <= i_cfg_data[4:0];
                    REG_ENDIAN: r_cfg.little <= i_cfg_data[0];
                    REG_THREE:  r_cfg.three <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        // merge the lanes into one result beat
        if (s_axis_tvalid && s_axis_tready)
            r_data <= {r_cfg.three ? z_b : 32'd0, y_b, x_b};
    end
endmodule

### sv/vpd_checker.sv
// port-level checks for the top level, bound in below
// depends on assert_macros.svh
`include "assert_macros.svh"
module vpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output not held")
    `ASSERT_CLK(a_accept_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "accepted beat lost")
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled while empty")
endmodule
bind vertex_position_dequantize vpd_checker u_vpd_checker (.*);

### test/vertex_position_dequantize_test.sv
// self-checking bench for vertex_position_dequantize: streams packed position
// records through the block under varying register settings and compares each
// output beat with a built-in decoder; depends on vpd_pkg and the block rtl
`timescale 1ns / 1ps

module vertex_position_dequantize_test;
    import vpd_pkg::*;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_xyz;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // raw_front[63:0], raw_back[95:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // x_bits[31:0], y_bits[63:32], z_bits[95:64]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    vertex_position_dequantize uut (.*);

    // register shadow used by the decoder
    t_cfg cfg_shadow;

    logic [95:0] record_queue[$];
    t_xyz        xyz_expected[$];
    int          mismatch_count;
    bit          s_steady;     // no idling on the send side
    bit          m_steady;     // no stalls on the receive side

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // record byte i, byte 0 in bits 63:56 of the front word
    function automatic logic [7:0] rec_byte(logic [95:0] rec, int unsigned i);
        if (i < 8) return rec[63 - 8*i -: 8];
        if (i < 12) return rec[64 + 31 - 8*(i-8) -: 8];
        return 8'h00;
    endfunction

    // exact int to float with scaling by 2^-frac; magnitudes fit in 24 bits
    function automatic logic [31:0] int_to_float(int signed v, logic [4:0] frac);
        logic        sgn;
        logic [31:0] mag;
        logic [22:0] mant;
        int          msb;
        if (v == 0) return 32'h0;
        sgn = v < 0;
        mag = sgn ? -v : v;
        msb = 0;
        for (int k = 0; k < 32; k++) if (mag[k]) msb = k;
        mant = 23'((mag << (23 - msb)) & 32'h007f_ffff);
        return {sgn, 8'(127 + msb - int'(frac)), mant};
    endfunction

    function automatic logic [31:0] decode_component(logic [95:0] rec, int unsigned at);
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] h;
        b0 = rec_byte(rec, at);
        b1 = rec_byte(rec, at + 1);
        b2 = rec_byte(rec, at + 2);
        b3 = rec_byte(rec, at + 3);
        h = cfg_shadow.little ? {b1, b0} : {b0, b1};
        case (cfg_shadow.comp_type)
            CT_U8:  return int_to_float(int'(b0), cfg_shadow.frac);
            CT_S8:  return int_to_float(int'($signed(b0)), cfg_shadow.frac);
            CT_U16: return int_to_float(int'(h), cfg_shadow.frac);
            CT_S16: return int_to_float(int'($signed(h)), cfg_shadow.frac);
            CT_F32: return cfg_shadow.little ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
            default: return 32'h0;
        endcase
    endfunction

    function automatic t_xyz decode_position(logic [95:0] rec);
        t_xyz r;
        int unsigned stride;
        stride = (cfg_shadow.comp_type == CT_F32) ? 4 :
                 (cfg_shadow.comp_type == CT_U16 || cfg_shadow.comp_type == CT_S16) ? 2 : 1;
        r.x = decode_component(rec, 0);
        r.y = decode_component(rec, stride);
        r.z = cfg_shadow.three ? decode_component(rec, 2*stride) : 32'h0;
        return r;
    endfunction

    // append one record to the pending queue
    task automatic queue_record(logic [95:0] rec);
        record_queue = {record_queue, rec};
    endtask

    // driver: feeds the record queue, about a third of cycles idle unless s_steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (record_queue.size() > 0 && (s_steady || $urandom_range(99) >= 34)) begin
                s_axis_tdata  <= record_queue[0];
                s_axis_tvalid <= 1'b1;
                xyz_expected = {xyz_expected, decode_position(record_queue[0])};
                void'(record_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receive side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= m_steady || ($urandom_range(99) >= 34);
    end

    // monitor: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_xyz got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (xyz_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected beat %h", got);
            end else begin
                want = xyz_expected.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected x %h y %h z %h, got x %h y %h z %h",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TYPE:   cfg_shadow.comp_type = value[2:0];
            REG_FRAC:   cfg_shadow.frac = value[4:0];
            REG_ENDIAN: cfg_shadow.little = value[0];
            REG_THREE:  cfg_shadow.three = value[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [2:0] ct, logic [4:0] fr, logic le, logic th);
        write_reg(REG_TYPE, {29'h0, ct});
        write_reg(REG_FRAC, {27'h0, fr});
        write_reg(REG_ENDIAN, {31'h0, le});
        write_reg(REG_THREE, {31'h0, th});
    endtask

    // let the previous phase drain before touching registers
    task automatic drain;
        while (record_queue.size() > 0 || xyz_expected.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [95:0] random_record();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_steady = 1'b0;
        m_steady = 1'b0;
        mismatch_count = 0;
        cfg_shadow = '{comp_type: CT_U8, frac: 5'd0, little: 1'b0, three: 1'b1};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, field extremes, then each type at extremes
        queue_record('0);
        queue_record({96{1'b1}});
        queue_record(96'h0000_0000_7f80_ff01_8000_0001);
        drain();
        for (int t = 0; t < 8; t++) begin
            set_all(3'(t), (t % 2) ? 5'd31 : 5'd0, t[1], t != 3);
            queue_record({32'h0, 64'h8000_7fff_0000_0000});
            queue_record({32'h7fc0_0001, 64'h8000_0000_ff80_0000});
            queue_record({32'hffff_ffff, 64'h0080_ff7f_0180_7f00});
            drain();
        end

        // random phases across register settings, long no-idle stretch in one
        for (int ph = 0; ph < 21; ph++) begin
            set_all(3'($urandom_range(7)), (ph % 3 == 0) ? 5'd31 :
                    (ph % 3 == 1) ? 5'd0 : 5'($urandom_range(31)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
            s_steady = (ph == 10);
            m_steady = (ph == 10);
            for (int n = 0; n < 50; n++) queue_record(random_record());
            drain();
        end
        s_steady = 1'b0;
        m_steady = 1'b0;
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && xyz_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

### vertex_position_dequantize.f
+incdir+sv
sv/vpd_pkg.sv
sv/vpd_lane.sv
sv/vertex_position_dequantize.sv
sv/vpd_checker.sv
test/vertex_position_dequantize_test.sv
